>>> rtl/core/bcq_pkg.sv
package bcq_pkg;

  // widest slot count the register map and job format are laid out for
  localparam int unsigned MaxSlots = 4;
  localparam int unsigned SlotIdxW = 2;
  localparam int unsigned IdW      = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  // event entry: {pressed, timestamp, id}
  localparam int unsigned EntryW = 1 + TimeW + IdW;

  localparam logic [HoldW-1:0] HoldReset = 16'd100;

  // register indexes (byte address / 4)
  localparam logic [2:0] RegEnable = 3'd0;
  localparam logic [2:0] RegHold   = 3'd1;
  localparam logic [2:0] RegId0    = 3'd2;
  localparam logic [2:0] RegId1    = 3'd3;
  localparam logic [2:0] RegId2    = 3'd4;
  localparam logic [2:0] RegId3    = 3'd5;

  typedef struct packed {
    logic                command;
    logic [TimeW-1:0]    now_ms;
    logic [MaxSlots-1:0] change;
    logic [MaxSlots-1:0] state;
  } job_t;

  typedef struct packed {
    logic [IdW-1:0]   id_mask;
    logic             pressed;
    logic [TimeW-1:0] timestamp_ms;
    logic             events_lost;
  } result_t;

  typedef struct packed {
    logic [HoldW-1:0]              hold_ms;
    logic [MaxSlots-1:0][IdW-1:0]  ids;
  } back_cfg_t;

endpackage

>>> rtl/core/bcq_if.sv
interface bcq_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [3:0]  levels;
  logic [31:0] now_ms;

  modport source (output valid, command, levels, now_ms, input ready);
  modport sink   (input valid, command, levels, now_ms, output ready);
endinterface

interface bcq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] id_mask;
  logic        pressed;
  logic [31:0] timestamp_ms;
  logic        events_lost;

  modport source (output valid, id_mask, pressed, timestamp_ms, events_lost, input ready);
  modport sink   (input valid, id_mask, pressed, timestamp_ms, events_lost, output ready);
endinterface

>>> rtl/core/bcq_ram.sv
module bcq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bcq_front.sv
module bcq_front #(
  parameter int unsigned NumSlots = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [3:0]           levels_i,
  input  logic [31:0]          now_ms_i,
  input  logic [NumSlots-1:0]  enable_i,
  input  logic                 enable_wr_i,
  input  logic [NumSlots-1:0]  enable_wdata_i,
  output logic                 job_valid_o,
  output bcq_pkg::job_t        job_o,
  input  logic                 job_ready_i
);
  import bcq_pkg::*;

  logic [NumSlots-1:0] last_q, last_d;
  logic [NumSlots-1:0] now_pressed;
  logic [NumSlots-1:0] change;
  logic                accept;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i & job_ready_i;
  assign now_pressed = ~levels_i[NumSlots-1:0];
  assign change      = (now_pressed ^ last_q) & enable_i;

  always_comb begin
    last_d = last_q;
    if (accept) begin
      last_d = last_q ^ change;
    end
    // a disabled slot falls back to released
    if (enable_wr_i) begin
      last_d = last_q & enable_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

  assign job_valid_o    = in_valid_i;
  assign job_o.command  = command_i;
  assign job_o.now_ms   = now_ms_i;
  assign job_o.change   = MaxSlots'(change);
  assign job_o.state    = MaxSlots'(now_pressed);

endmodule

>>> rtl/core/bcq_job_fifo.sv
module bcq_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bcq_pkg::job_t push_data_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bcq_pkg::job_t pop_data_o
);
  import bcq_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign ready_o    = (cnt_q != 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i & ready_o;
  assign do_pop     = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/core/bcq_back.sv
module bcq_back #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  bcq_pkg::job_t       job_i,
  output logic                job_pop_o,
  input  bcq_pkg::back_cfg_t  cfg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcq_pkg::result_t    out_data_o
);
  import bcq_pkg::*;

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [2:0] {
    StIdle, StPush, StRead, StFirst, StNext, StCommit, StDone
  } state_e;

  state_e           state_q, state_d;
  job_t             job_q, job_d;
  logic [PW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    taken_q, taken_d;
  logic             lost_q, lost_d;
  logic [IdW-1:0]   acc_id_q, acc_id_d;
  logic             acc_state_q, acc_state_d;
  logic [TimeW-1:0] acc_ts_q, acc_ts_d;
  result_t          res_q, res_d;
  logic             out_valid_q, out_valid_d;

  logic              ram_we, ram_re;
  logic [PW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  logic [SlotIdxW-1:0] slot;
  logic [CW-1:0]       taken_inc;
  logic [TimeW-1:0]    age;
  logic [IdW-1:0]      rd_id;
  logic [TimeW-1:0]    rd_ts;
  logic                rd_state;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(QueueDepth)) begin
      s = s - SW'(QueueDepth);
    end
    return s[PW-1:0];
  endfunction

  bcq_ram #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_event_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_id     = ram_rdata[IdW-1:0];
  assign rd_ts     = ram_rdata[IdW +: TimeW];
  assign rd_state  = ram_rdata[EntryW-1];
  assign age       = job_q.now_ms - rd_ts;
  assign taken_inc = taken_q + CW'(1);

  // lowest pending slot first, as the scan runs in slot order
  always_comb begin
    slot = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (job_q.change[i]) begin
        slot = SlotIdxW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    head_d      = head_q;
    count_d     = count_q;
    taken_d     = taken_q;
    lost_d      = lost_q;
    acc_id_d    = acc_id_q;
    acc_state_d = acc_state_q;
    acc_ts_d    = acc_ts_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    job_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wrap_add(head_q, count_q);
    ram_wdata   = {job_q.state[slot], job_q.now_ms, cfg_i.ids[slot]};
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          state_d   = StPush;
        end
      end
      StPush: begin
        if (job_q.change == '0) begin
          state_d = job_q.command ? StRead : StIdle;
        end else begin
          job_d.change[slot] = 1'b0;
          if (count_q == CW'(QueueDepth)) begin
            lost_d = 1'b1;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
      end
      StRead: begin
        acc_id_d    = '0;
        acc_state_d = 1'b0;
        acc_ts_d    = '0;
        taken_d     = '0;
        if (count_q == '0) begin
          state_d = StCommit;
        end else begin
          ram_re  = 1'b1;
          state_d = StFirst;
        end
      end
      StFirst: begin
        state_d = StCommit;
        if (age > TimeW'(cfg_i.hold_ms)) begin
          acc_id_d    = rd_id;
          acc_state_d = rd_state;
          acc_ts_d    = rd_ts;
          taken_d     = CW'(1);
          if (CW'(1) < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = wrap_add(head_q, CW'(1));
            state_d   = StNext;
          end
        end
      end
      StNext: begin
        state_d = StCommit;
        if (rd_state == acc_state_q) begin
          acc_id_d = acc_id_q | rd_id;
          taken_d  = taken_inc;
          if (taken_inc < count_q) begin
            ram_re    = 1'b1;
            ram_raddr = wrap_add(head_q, taken_inc);
            state_d   = StNext;
          end
        end
      end
      StCommit: begin
        head_d  = wrap_add(head_q, taken_q);
        count_d = count_q - taken_q;
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          res_d.id_mask      = acc_id_q;
          res_d.pressed      = acc_state_q;
          res_d.timestamp_ms = acc_ts_q;
          res_d.events_lost  = lost_q;
          lost_d             = 1'b0;
          out_valid_d        = 1'b1;
          state_d            = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      count_q     <= '0;
      lost_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      lost_q      <= lost_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    taken_q     <= taken_d;
    acc_id_q    <= acc_id_d;
    acc_state_q <= acc_state_d;
    acc_ts_q    <= acc_ts_d;
    res_q       <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

>>> rtl/core/button_chord_event_queue.sv
// Button chord event queue. Each request samples the active-low button levels with the
// current millisecond time; every enabled slot whose pressed state changed queues an event
// (slot id, new state, time) in slot order. A request with command 1 then releases the
// oldest event if its age exceeds hold_ms, merging the ids of the following events of the
// same state, and returns one result (all zeros besides events_lost when nothing is due).
// Events that find the QUEUE_DEPTH-entry queue full are dropped and reported in
// events_lost of the next result. The front classifies a request combinationally and
// hands it through a two-entry job queue to the back, which retires it one step at a
// time: it takes the job, queues the event of each changed slot, and on a read examines
// the oldest event and then each following event of the same state (one event-memory
// read per cycle), commits the new head and count and posts the result. Registers:
// 0 button_enable, 1 hold_ms, 2..5 button_id_0..3 at byte address 4*index; write
// configuration only while idle.
module button_chord_event_queue #(
  parameter int unsigned NUM_SLOTS   = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bcq_in_if.sink                      req_i,
  bcq_out_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcq_pkg::AddrW-1:0]   paddr,
  input  logic [bcq_pkg::DataW-1:0]   pwdata,
  output logic [bcq_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import bcq_pkg::*;

  logic [NUM_SLOTS-1:0]         enable_q, enable_d;
  logic [HoldW-1:0]             hold_q, hold_d;
  logic [MaxSlots-1:0][IdW-1:0] id_q, id_d;
  logic                         cfg_wr;
  logic                         enable_wr;
  logic [2:0]                   reg_idx;

  job_t      front_job, fifo_job;
  logic      front_valid, fifo_ready, fifo_valid, fifo_pop;
  back_cfg_t back_cfg;
  result_t   result;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    enable_d  = enable_q;
    hold_d    = hold_q;
    id_d      = id_q;
    enable_wr = 1'b0;
    if (cfg_wr) begin
      unique case (reg_idx)
        RegEnable: begin
          enable_d  = pwdata[NUM_SLOTS-1:0];
          enable_wr = 1'b1;
        end
        RegHold: hold_d    = pwdata[HoldW-1:0];
        RegId0:  id_d[0]   = pwdata;
        RegId1:  id_d[1]   = pwdata;
        RegId2:  id_d[2]   = pwdata;
        RegId3:  id_d[3]   = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegEnable: prdata = DataW'(enable_q);
      RegHold:   prdata = DataW'(hold_q);
      RegId0:    prdata = id_q[0];
      RegId1:    prdata = id_q[1];
      RegId2:    prdata = id_q[2];
      RegId3:    prdata = id_q[3];
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      hold_q   <= HoldReset;
      id_q     <= '0;
    end else begin
      enable_q <= enable_d;
      hold_q   <= hold_d;
      id_q     <= id_d;
    end
  end

  bcq_front #(
    .NumSlots (NUM_SLOTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .command_i      (req_i.command),
    .levels_i       (req_i.levels),
    .now_ms_i       (req_i.now_ms),
    .enable_i       (enable_q),
    .enable_wr_i    (enable_wr),
    .enable_wdata_i (enable_d),
    .job_valid_o    (front_valid),
    .job_o          (front_job),
    .job_ready_i    (fifo_ready)
  );

  bcq_job_fifo u_job_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_job),
    .ready_o     (fifo_ready),
    .pop_i       (fifo_pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (fifo_job)
  );

  assign back_cfg.hold_ms = hold_q;
  assign back_cfg.ids     = id_q;

  bcq_back #(
    .QueueDepth (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (fifo_valid),
    .job_i       (fifo_job),
    .job_pop_o   (fifo_pop),
    .cfg_i       (back_cfg),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (result)
  );

  assign rsp_o.id_mask      = result.id_mask;
  assign rsp_o.pressed      = result.pressed;
  assign rsp_o.timestamp_ms = result.timestamp_ms;
  assign rsp_o.events_lost  = result.events_lost;

endmodule

>>> dv/button_chord_event_queue_tb.sv
module button_chord_event_queue_tb;
  import bcq_pkg::*;

  localparam int unsigned EventDepth  = 16;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned DirRows     = 24;

  // addresses past the last register, writes there must have no effect
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  localparam result_t NoRelease = '0;

  typedef enum logic [1:0] {RxOpen, RxCoin, RxPeriodic, RxMostly} rx_mode_e;

  typedef struct {
    logic [IdW-1:0]   id;
    logic             pressed;
    logic [TimeW-1:0] ts;
  } chord_event_t;

  typedef struct {
    bit               cmd;
    logic [3:0]       lev;
    logic [TimeW-1:0] now;
    bit               typed;
    result_t          want;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  bcq_in_if  req_if ();
  bcq_out_if rsp_if ();

  button_chord_event_queue uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of the block state
  logic [MaxSlots-1:0] cfg_enable;
  logic [HoldW-1:0]    cfg_hold;
  logic [IdW-1:0]      cfg_id [MaxSlots];
  logic [MaxSlots-1:0] held;
  bit                  lost_seen;
  chord_event_t        queued_events [$];
  result_t             due_results [$];

  int       mismatches = 0;
  int       rx_cycle = 0;
  rx_mode_e rx_mode = RxOpen;

  // directed rows: ids are 1, 2, 8000_0000 and 0000_ff00, hold is 10
  dir_row_t dir_rows [DirRows] = '{
    '{1'b1, 4'hF, 32'hFFFF_FFFF, 1'b1, '0},
    '{1'b0, 4'hE, 32'd1000,      1'b0, '0},
    '{1'b1, 4'hE, 32'd1005,      1'b1, '0},
    '{1'b1, 4'hE, 32'd1010,      1'b1, '0},
    '{1'b1, 4'hE, 32'd1011,      1'b1, '{32'h1, 1'b1, 32'd1000, 1'b0}},
    '{1'b0, 4'h0, 32'd2000,      1'b0, '0},
    '{1'b0, 4'hF, 32'd2001,      1'b0, '0},
    '{1'b1, 4'hF, 32'd3000,      1'b1, '{32'h8000_FF02, 1'b1, 32'd2000, 1'b0}},
    '{1'b1, 4'hF, 32'd3001,      1'b1, '{32'h8000_FF03, 1'b0, 32'd2001, 1'b0}},
    '{1'b1, 4'hF, 32'd3002,      1'b1, '0},
    '{1'b0, 4'h0, 32'd4000,      1'b0, '0},
    '{1'b0, 4'hF, 32'd4001,      1'b0, '0},
    '{1'b0, 4'h0, 32'd4002,      1'b0, '0},
    '{1'b0, 4'hF, 32'd4003,      1'b0, '0},
    '{1'b0, 4'h0, 32'd4004,      1'b0, '0},
    '{1'b1, 4'h0, 32'd4100,      1'b1, '{32'h8000_FF03, 1'b1, 32'd4000, 1'b1}},
    '{1'b1, 4'h0, 32'd4101,      1'b0, '0},
    '{1'b1, 4'hF, 32'd4102,      1'b0, '0},
    '{1'b1, 4'hF, 32'd5000,      1'b0, '0},
    '{1'b0, 4'hB, 32'hFFFF_FFFA, 1'b0, '0},
    '{1'b1, 4'hB, 32'd5,         1'b1, '{32'h8000_0000, 1'b1, 32'hFFFF_FFFA, 1'b0}},
    '{1'b1, 4'hF, 32'd4,         1'b0, '0},
    '{1'b0, 4'h0, 32'd100,       1'b0, '0},
    '{1'b1, 4'h0, 32'd200,       1'b0, '0}
  };

  function automatic bit predict_release(input bit cmd, input logic [3:0] lev,
                                         input logic [TimeW-1:0] now, output result_t res);
    logic [MaxSlots-1:0] down;
    logic [TimeW-1:0]    age;
    chord_event_t        ev;
    down = ~lev;
    res  = NoRelease;
    for (int s = 0; s < MaxSlots; s++) begin
      if (cfg_enable[s] && down[s] != held[s]) begin
        held[s] = down[s];
        if (queued_events.size() >= EventDepth) begin
          lost_seen = 1'b1;
        end else begin
          ev.id      = cfg_id[s];
          ev.pressed = down[s];
          ev.ts      = now;
          queued_events = {queued_events, ev};
        end
      end
    end
    if (!cmd) return 1'b0;
    if (queued_events.size() > 0) begin
      age = now - queued_events[0].ts;
      if (age > {16'd0, cfg_hold}) begin
        res.id_mask      = queued_events[0].id;
        res.pressed      = queued_events[0].pressed;
        res.timestamp_ms = queued_events[0].ts;
        void'(queued_events.pop_front());
        // merge the run of same-state events behind the oldest one
        while (queued_events.size() > 0 && queued_events[0].pressed == res.pressed) begin
          res.id_mask |= queued_events[0].id;
          void'(queued_events.pop_front());
        end
      end
    end
    res.events_lost = lost_seen;
    lost_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s; want id %h pressed %b ts %h lost %b, %s %h %s %b %s %h %s %b",
               $time, what, want.id_mask, want.pressed, want.timestamp_ms, want.events_lost,
               "got id", got.id_mask, "pressed", got.pressed, "ts", got.timestamp_ms,
               "lost", got.events_lost);
  endfunction

  task automatic send_request(input bit cmd, input logic [3:0] lev,
                              input logic [TimeW-1:0] now, input bit typed, input result_t want);
    result_t res;
    result_t due;
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.levels  <= lev;
    req_if.now_ms  <= now;
    do @(posedge clk_i); while (!req_if.ready);
    if (predict_release(cmd, lev, now, res)) begin
      due = typed ? want : res;
      due_results = {due_results, due};
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegEnable: begin
        cfg_enable = val[MaxSlots-1:0];
        held       = held & cfg_enable;
      end
      RegHold: cfg_hold = val[HoldW-1:0];
      RegId0, RegId1, RegId2, RegId3: cfg_id[SlotIdxW'(idx - RegId0)] = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // let every release come back, then cover requests still being scanned
  task automatic settle();
    req_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int count);
    logic [TimeW-1:0] tnow;
    logic [3:0]       lev;
    bit               cmd;
    int               burst;
    int               r;
    burst = 0;
    tnow  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF80 : $urandom;
    lev   = 4'($urandom_range(0, 15));
    for (int n = 0; n < count; n++) begin
      if (burst == 0 || n == count / 2) begin
        req_if.valid <= 1'b0;
        if (n == count / 2) while (due_results.size() != 0) @(posedge clk_i);
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 16);
      end
      r = $urandom_range(0, 99);
      if (r < 65)      tnow += $urandom_range(0, 12);
      else if (r < 88) tnow += $urandom_range(0, 2 * cfg_hold + 24);
      else if (r < 95) tnow += $urandom_range(60000, 140000);
      else             tnow = $urandom;
      r = $urandom_range(0, 99);
      if (r < 55)      lev ^= 4'b0001 << $urandom_range(0, 3);
      else if (r < 70) lev ^= 4'($urandom_range(0, 15));
      else if (r > 89) lev = 4'($urandom_range(0, 15));
      cmd = ($urandom_range(0, 9) < 3);
      send_request(cmd, lev, tnow, 1'b0, NoRelease);
      burst--;
    end
  endtask

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // receiver stalls on its own pattern, which it switches at random
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RxOpen:     rsp_if.ready <= 1'b1;
      RxCoin:     rsp_if.ready <= 1'($urandom_range(0, 1));
      RxPeriodic: rsp_if.ready <= (rx_cycle % 6 == 0);
      default:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.id_mask, rsp_if.pressed, rsp_if.timestamp_ms, rsp_if.events_lost};
      if (due_results.size() == 0) begin
        note_mismatch("result with no request pending", NoRelease, got);
      end else begin
        want = due_results.pop_front();
        if (got.id_mask !== want.id_mask || got.pressed !== want.pressed ||
            got.timestamp_ms !== want.timestamp_ms || got.events_lost !== want.events_lost)
          note_mismatch("wrong release", want, got);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    req_if.valid   <= 1'b0;
    req_if.command <= 1'b0;
    req_if.levels  <= 4'hF;
    req_if.now_ms  <= '0;
    cfg_enable = '0;
    cfg_hold   = HoldReset;
    for (int s = 0; s < MaxSlots; s++) cfg_id[s] = '0;
    held      = '0;
    lost_seen = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      if (i == 1) begin
        settle();
        write_reg(RegEnable, 32'hF);
        write_reg(RegHold, 32'd10);
        write_reg(RegId0, 32'h0000_0001);
        write_reg(RegId1, 32'h0000_0002);
        write_reg(RegId2, 32'h8000_0000);
        write_reg(RegId3, 32'h0000_FF00);
        write_reg(RegSpareLo, $urandom);
        write_reg(RegSpareHi, $urandom);
      end
      send_request(dir_rows[i].cmd, dir_rows[i].lev, dir_rows[i].now,
                   dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(RegEnable, 32'hF);
          write_reg(RegHold, 32'd20);
          write_reg(RegId0, $urandom);
          write_reg(RegId1, $urandom);
          write_reg(RegId2, $urandom);
          write_reg(RegId3, $urandom);
        end
        1: begin
          write_reg(RegEnable, $urandom_range(1, 14));
          write_reg(RegHold, 32'd0);
          write_reg(RegId0, 32'hFFFF_FFFF);
          write_reg(RegId1, 32'h0);
          write_reg(RegId2, $urandom);
          write_reg(RegId3, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(RegEnable, 32'hF);
          write_reg(RegHold, 32'hFFFF);
          write_reg(RegId0, $urandom);
          write_reg(RegId1, $urandom);
          write_reg(RegId2, $urandom);
          write_reg(RegId3, $urandom);
        end
        3: begin
          write_reg(RegEnable, 32'h0);
          write_reg(RegHold, $urandom_range(0, 65535));
        end
        default: begin
          write_reg(RegEnable, $urandom_range(0, 15));
          write_reg(RegHold, $urandom_range(0, 300));
          write_reg(RegId0, $urandom);
          write_reg(RegId1, $urandom);
          write_reg(RegId2, $urandom);
          write_reg(RegId3, $urandom);
        end
      endcase
      run_phase((p == 3) ? 150 : 450);
    end

    settle();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> button_chord_event_queue.f
rtl/core/bcq_pkg.sv
rtl/core/bcq_if.sv
rtl/core/bcq_ram.sv
rtl/core/bcq_front.sv
rtl/core/bcq_job_fifo.sv
rtl/core/bcq_back.sv
rtl/core/button_chord_event_queue.sv
dv/button_chord_event_queue_tb.sv
